FILE: src/dba_pkg.sv
// dba_pkg: shared types and codes for the disk block allocator.
// No dependencies; compiled before every other file.
`default_nettype none

package dba_pkg;

  // Field widths fixed by the request and result formats
  localparam int ID_W    = 8;
  localparam int CNT_W   = 7;
  localparam int DIR_W   = ID_W + CNT_W;

  // Request actions
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  // Block table marks
  typedef enum logic [1:0] {
    MARK_FREE   = 2'd0,
    MARK_START  = 2'd1,
    MARK_MIDDLE = 2'd2,
    MARK_END    = 2'd3
  } dba_mark_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_SPACE  = 2'd1,
    ST_DIR_FULL  = 2'd2,
    ST_NOT_FOUND = 2'd3
  } dba_status_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_CLEAR,   // sweep table and directory after reset or size write
    S_IDLE,    // waiting for a request
    S_FIND,    // streaming table reads for the first free block
    S_RUN,     // checking the rest of the run is free
    S_DSCAN,   // streaming directory reads for a slot or an id
    S_MARK,    // writing the run marks
    S_WALK,    // freeing blocks up to the end mark
    S_DONE     // handing the result to the output register
  } dba_state_t;

endpackage

`default_nettype wire

FILE: src/dba_if.sv
// dba_in_if / dba_out_if: valid/ready channels for requests and results.
// Depends on dba_pkg for the field widths.
`default_nettype none

interface dba_in_if import dba_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             action;
  logic [ID_W-1:0]  file_id;
  logic [CNT_W-1:0] block_count;

  modport source (output valid, action, file_id, block_count, input ready);
  modport sink   (input valid, action, file_id, block_count, output ready);
endinterface

interface dba_out_if import dba_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic [CNT_W-1:0] start_block;
  logic [CNT_W-1:0] free_count;

  modport source (output valid, status, start_block, free_count, input ready);
  modport sink   (input valid, status, start_block, free_count, output ready);
endinterface

`default_nettype wire

FILE: src/dba_ram.sv
// dba_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none

module dba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: src/disk_block_allocator.sv
// disk_block_allocator: contiguous block allocator with a file directory.
// Depends on dba_pkg, dba_in_if / dba_out_if and dba_ram.
//
//   channel   | dir | handshake          | payload
//   ----------+-----+--------------------+-------------------------------------
//   in_ch     | in  | valid / ready      | action, file_id, block_count
//   out_ch    | out | valid / ready      | status, start_block, free_count
//   cfg_*     | in  | cfg_we (no stall)  | cfg_wdata = disk_blocks
//
// One request at a time, one table or directory entry per cycle through the
// RAM port. Allocate finds the first free block, checks the rest of the run
// from there only, takes a directory slot and writes the marks; free finds
// the directory entry and walks the blocks to the end mark. Reset and every
// cfg write start a clearing pass during which no request is taken.
// A finished result sits in the output register, so the next request is
// taken while it waits for out_ch.ready.
`default_nettype none

module disk_block_allocator import dba_pkg::*; #(
  parameter int NUM_BLOCKS  = 64,
  parameter int DIR_ENTRIES = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  dba_in_if.sink                in_ch,
  dba_out_if.source             out_ch,
  input  wire logic             cfg_we,
  input  wire logic [CNT_W-1:0] cfg_wdata
);

  localparam int BW = $clog2(NUM_BLOCKS);
  localparam int DW = (DIR_ENTRIES > 1) ? $clog2(DIR_ENTRIES) : 1;
  localparam int IW = ($clog2(DIR_ENTRIES + 2) > 8) ? $clog2(DIR_ENTRIES + 2) : 8;
  localparam logic [CNT_W-1:0] DB_RESET =
    (NUM_BLOCKS < 64) ? CNT_W'(NUM_BLOCKS) : CNT_W'(64);

  dba_state_t       state_r, state_nxt;
  logic [IW-1:0]    idx_r, idx_nxt;
  logic             dvld_r, dvld_nxt;
  logic [CNT_W-1:0] disk_blocks_r;
  logic [CNT_W-1:0] free_total_r, free_nxt;
  logic [CNT_W-1:0] f_r, f_nxt;
  logic [CNT_W-1:0] start_r, start_nxt;
  dba_status_t      status_r, status_nxt;
  logic             req_act_r;
  logic [ID_W-1:0]  req_id_r;
  logic [CNT_W-1:0] req_cnt_r;

  logic             out_valid_r;
  dba_status_t      out_status_r;
  logic [CNT_W-1:0] out_start_r;
  logic [CNT_W-1:0] out_free_r;
  logic             load_out;

  logic             in_fire;
  logic [CNT_W-1:0] cfg_v;
  logic [IW-1:0]    db;
  logic [IW-1:0]    chk_i;
  logic [IW-1:0]    last_i;

  // block table RAM
  logic             blk_we;
  logic [BW-1:0]    blk_waddr, blk_raddr;
  logic [1:0]       blk_wdata, blk_rdata;

  // directory RAM: {file id, zero-based start block}
  logic             dir_we;
  logic [DW-1:0]    dir_waddr, dir_raddr;
  logic [DIR_W-1:0] dir_wdata, dir_rdata;
  logic [ID_W-1:0]  dir_file;
  logic [CNT_W-1:0] dir_start;
  logic             dir_hit;

  dba_ram #(.WIDTH(2), .DEPTH(NUM_BLOCKS)) u_blk_ram (
    .clk   (clk),
    .we    (blk_we),
    .waddr (blk_waddr),
    .wdata (blk_wdata),
    .raddr (blk_raddr),
    .rdata (blk_rdata)
  );

  dba_ram #(.WIDTH(DIR_W), .DEPTH(DIR_ENTRIES)) u_dir_ram (
    .clk   (clk),
    .we    (dir_we),
    .waddr (dir_waddr),
    .wdata (dir_wdata),
    .raddr (dir_raddr),
    .rdata (dir_rdata)
  );

  // Size register clamp: zero reads as one, oversize as the table depth
  always_comb begin
    if (cfg_wdata == '0) begin
      cfg_v = CNT_W'(1);
    end else if (32'(cfg_wdata) > NUM_BLOCKS) begin
      cfg_v = CNT_W'(NUM_BLOCKS);
    end else begin
      cfg_v = cfg_wdata;
    end
  end

  assign in_fire   = in_ch.valid && in_ch.ready;
  assign db        = IW'(disk_blocks_r);
  // RAM data on the port belongs to the address issued in the previous cycle
  assign chk_i     = idx_r - IW'(1);
  assign last_i    = IW'(f_r) + IW'(req_cnt_r) - IW'(1);
  assign dir_file  = dir_rdata[DIR_W-1:CNT_W];
  assign dir_start = dir_rdata[CNT_W-1:0];
  assign dir_hit   = (req_act_r == ACT_ALLOC) ? (dir_file == '0) : (dir_file == req_id_r);

  // Sequencer: next state, RAM accesses and result
  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    dvld_nxt   = 1'b0;
    f_nxt      = f_r;
    start_nxt  = start_r;
    status_nxt = status_r;
    free_nxt   = free_total_r;
    blk_we     = 1'b0;
    blk_waddr  = BW'(idx_r);
    blk_wdata  = MARK_FREE;
    blk_raddr  = BW'(idx_r);
    dir_we     = 1'b0;
    dir_waddr  = DW'(idx_r);
    dir_wdata  = '0;
    dir_raddr  = DW'(idx_r);
    in_ch.ready = 1'b0;
    load_out   = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        blk_we  = (idx_r < db);
        dir_we  = (idx_r < IW'(DIR_ENTRIES));
        idx_nxt = idx_r + IW'(1);
        if ((idx_r + IW'(1) >= db) && (idx_r + IW'(1) >= IW'(DIR_ENTRIES))) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          idx_nxt    = '0;
          start_nxt  = '0;
          status_nxt = ST_OK;
          if (in_ch.action == ACT_ALLOC) begin
            if (in_ch.block_count == '0) begin
              status_nxt = ST_NO_SPACE;
              state_nxt  = S_DONE;
            end else begin
              state_nxt = S_FIND;
            end
          end else if (in_ch.file_id == '0) begin
            status_nxt = ST_NOT_FOUND;
            state_nxt  = S_DONE;
          end else begin
            state_nxt = S_DSCAN;
          end
        end
      end

      // first free block, one entry per cycle
      S_FIND: begin
        idx_nxt  = idx_r + IW'(1);
        dvld_nxt = 1'b1;
        if (dvld_r) begin
          if (blk_rdata == MARK_FREE) begin
            f_nxt = CNT_W'(chk_i);
            if (IW'(req_cnt_r) > (db - chk_i)) begin
              status_nxt = ST_NO_SPACE;
              state_nxt  = S_DONE;
            end else if (req_cnt_r == CNT_W'(1)) begin
              idx_nxt  = '0;
              dvld_nxt = 1'b0;
              if (req_id_r == '0) begin
                status_nxt = ST_DIR_FULL;
                state_nxt  = S_DONE;
              end else begin
                state_nxt = S_DSCAN;
              end
            end else begin
              state_nxt = S_RUN;
            end
          end else if (chk_i + IW'(1) >= db) begin
            status_nxt = ST_NO_SPACE;
            state_nxt  = S_DONE;
          end
        end
      end

      // hole check over the rest of the run
      S_RUN: begin
        idx_nxt  = idx_r + IW'(1);
        dvld_nxt = 1'b1;
        if (dvld_r) begin
          if (blk_rdata != MARK_FREE) begin
            status_nxt = ST_NO_SPACE;
            state_nxt  = S_DONE;
          end else if (chk_i == last_i) begin
            idx_nxt  = '0;
            dvld_nxt = 1'b0;
            if (req_id_r == '0) begin
              status_nxt = ST_DIR_FULL;
              state_nxt  = S_DONE;
            end else begin
              state_nxt = S_DSCAN;
            end
          end
        end
      end

      // directory: first empty slot for allocate, first match for free
      S_DSCAN: begin
        idx_nxt  = idx_r + IW'(1);
        dvld_nxt = 1'b1;
        if (dvld_r) begin
          if (dir_hit) begin
            dir_we    = 1'b1;
            dir_waddr = DW'(chk_i);
            dvld_nxt  = 1'b0;
            if (req_act_r == ACT_ALLOC) begin
              dir_wdata = {req_id_r, f_r};
              start_nxt = f_r + CNT_W'(1);
              idx_nxt   = IW'(f_r);
              state_nxt = S_MARK;
            end else begin
              start_nxt = dir_start + CNT_W'(1);
              idx_nxt   = IW'(dir_start);
              state_nxt = S_WALK;
            end
          end else if (chk_i + IW'(1) >= IW'(DIR_ENTRIES)) begin
            status_nxt = (req_act_r == ACT_ALLOC) ? ST_DIR_FULL : ST_NOT_FOUND;
            state_nxt  = S_DONE;
          end
        end
      end

      // write start / middle / end marks; a single block is marked end
      S_MARK: begin
        blk_we  = 1'b1;
        idx_nxt = idx_r + IW'(1);
        if (idx_r == last_i) begin
          blk_wdata  = MARK_END;
          free_nxt   = free_total_r - req_cnt_r;
          status_nxt = ST_OK;
          state_nxt  = S_DONE;
        end else if (idx_r == IW'(f_r)) begin
          blk_wdata = MARK_START;
        end else begin
          blk_wdata = MARK_MIDDLE;
        end
      end

      // free walk: read ahead, clear the block behind
      S_WALK: begin
        idx_nxt  = idx_r + IW'(1);
        dvld_nxt = 1'b1;
        if (dvld_r) begin
          blk_we    = 1'b1;
          blk_waddr = BW'(chk_i);
          if (blk_rdata != MARK_FREE) begin
            free_nxt = free_total_r + CNT_W'(1);
          end
          if ((blk_rdata == MARK_END) || (chk_i + IW'(1) >= db)) begin
            status_nxt = ST_OK;
            state_nxt  = S_DONE;
          end
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
    endcase
  end

  // Sequencer registers; a size write restarts the clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLEAR;
      idx_r         <= '0;
      dvld_r        <= 1'b0;
      disk_blocks_r <= DB_RESET;
      free_total_r  <= DB_RESET;
    end else if (cfg_we) begin
      state_r       <= S_CLEAR;
      idx_r         <= '0;
      dvld_r        <= 1'b0;
      disk_blocks_r <= cfg_v;
      free_total_r  <= cfg_v;
    end else begin
      state_r      <= state_nxt;
      idx_r        <= idx_nxt;
      dvld_r       <= dvld_nxt;
      free_total_r <= free_nxt;
    end
  end

  // Request and working payload
  always_ff @(posedge clk) begin
    f_r      <= f_nxt;
    start_r  <= start_nxt;
    status_r <= status_nxt;
    if (in_fire) begin
      req_act_r <= in_ch.action;
      req_id_r  <= in_ch.file_id;
      req_cnt_r <= in_ch.block_count;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status_r <= status_r;
      out_start_r  <= (status_r == ST_OK) ? start_r : '0;
      out_free_r   <= free_total_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.start_block = out_start_r;
  assign out_ch.free_count  = out_free_r;

  // Checks
  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    free_total_r <= disk_blocks_r)
    else $error("free block count exceeds disk size");

  a_start_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> ((out_ch.status == ST_OK) == (out_ch.start_block != '0)))
    else $error("start block does not agree with status");

  a_cfg_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> (state_r == S_CLEAR))
    else $error("size write did not start a clearing pass");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !cfg_we) |=> (state_r != S_IDLE))
    else $error("accepted transaction left the sequencer idle");

endmodule

`default_nettype wire
